// ----- design/rgbenc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbenc_pkg
// Shared types and constants for the RGB LED bit-slot encoder.
// ----------------------------------------------------------------------------
package rgbenc_pkg;

  localparam int unsigned ColourW    = 8;
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned IdxW       = 5;   // counts bit slots 0..24
  localparam int unsigned HoldW      = 8;
  localparam int unsigned CfgIdxW    = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ONE_DUTY    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ZERO_DUTY   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_SLOTS = 2'd2;

  localparam logic [HoldW-1:0] ResetSlotsDefault = 8'd48;
  localparam logic [HoldW-1:0] BitHold           = 8'd1;

  localparam logic [IdxW-1:0] LastBitIdx = 5'd23;
  localparam logic [IdxW-1:0] LatchIdx   = 5'd24;

  // one queued LED: packed G,R,B word plus the frame marker
  typedef struct packed {
    logic [BitsPerLed-1:0] bits;
    logic                  last_led;
  } led_word_t;

endpackage

// ----- design/rgbenc_if.sv -----
// ----------------------------------------------------------------------------
// rgbenc interfaces
// Valid/ready channels for LED colour words and bit-slot result words.
// ----------------------------------------------------------------------------
interface rgbenc_led_if;
  logic                            valid;
  logic                            ready;
  logic [rgbenc_pkg::ColourW-1:0]  green;
  logic [rgbenc_pkg::ColourW-1:0]  red;
  logic [rgbenc_pkg::ColourW-1:0]  blue;
  logic                            last_led;

  modport source (output valid, green, red, blue, last_led, input ready);
  modport sink   (input valid, green, red, blue, last_led, output ready);
endinterface

interface rgbenc_slot_if #(
  parameter int unsigned DUTY_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [DUTY_WIDTH-1:0]         duty;
  logic [rgbenc_pkg::HoldW-1:0]  hold_slots;
  logic                          frame_end;
  logic                          last;

  modport source (output valid, duty, hold_slots, frame_end, last, input ready);
  modport sink   (input valid, duty, hold_slots, frame_end, last, output ready);
endinterface

// ----- design/rgbenc_front.sv -----
// ----------------------------------------------------------------------------
// rgbenc_front
// Input stage: takes one colour word, packs it green-red-blue MSB first.
// ----------------------------------------------------------------------------
module rgbenc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rgbenc_led_if.sink             led_i,
  output logic                   push_o,
  output rgbenc_pkg::led_word_t  push_word_o,
  input  logic                   push_ready_i
);

  logic                  v_q, v_d;
  rgbenc_pkg::led_word_t word_q;
  logic                  take;

  assign led_i.ready = !v_q || push_ready_i;
  assign take        = led_i.valid && led_i.ready;

  always_comb begin
    v_d = v_q;
    if (take) begin
      v_d = 1'b1;
    end else if (push_ready_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q.bits     <= {led_i.green, led_i.red, led_i.blue};
      word_q.last_led <= led_i.last_led;
    end
  end

  assign push_o      = v_q;
  assign push_word_o = word_q;

endmodule

// ----- design/rgbenc_queue.sv -----
// ----------------------------------------------------------------------------
// rgbenc_queue
// Two-entry queue decoupling the input stage from the bit serialiser.
// ----------------------------------------------------------------------------
module rgbenc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rgbenc_pkg::led_word_t  push_word_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output rgbenc_pkg::led_word_t  pop_word_o,
  input  logic                   pop_i
);

  rgbenc_pkg::led_word_t ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_word_o   = ent_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ----- design/rgbenc_back.sv -----
// ----------------------------------------------------------------------------
// rgbenc_back
// Bit serialiser: a slot word per cycle unless stalled, plus latch reset slot.
// ----------------------------------------------------------------------------
module rgbenc_back #(
  parameter int unsigned DUTY_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rgbenc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [DUTY_WIDTH-1:0]              cfg_wdata_i,
  input  logic                               pop_valid_i,
  input  rgbenc_pkg::led_word_t              pop_word_i,
  output logic                               pop_o,
  rgbenc_slot_if.source                      slot_o
);

  logic [DUTY_WIDTH-1:0]                one_duty_q, zero_duty_q;
  logic [rgbenc_pkg::HoldW-1:0]         rst_slots_q;
  logic [rgbenc_pkg::HoldW-1:0]         latch_hold;

  logic                                 act_q, act_d;
  logic [rgbenc_pkg::BitsPerLed-1:0]    word_q;
  logic                                 fin_led_q;
  logic [rgbenc_pkg::IdxW-1:0]          idx_q;

  logic                                 ov_q;
  logic [DUTY_WIDTH-1:0]                duty_q;
  logic [rgbenc_pkg::HoldW-1:0]         hold_q;
  logic                                 fend_q, last_q;

  logic adv, emit, fin, pop;

  // a zero reset length still holds for one slot
  assign latch_hold = (rst_slots_q == '0) ? rgbenc_pkg::BitHold : rst_slots_q;

  assign adv  = !ov_q || slot_o.ready;
  assign emit = adv && act_q;
  assign fin  = ((idx_q == rgbenc_pkg::LastBitIdx) && !fin_led_q)
             || (idx_q == rgbenc_pkg::LatchIdx);
  // reload straight after the final slot so words run back to back
  assign pop  = pop_valid_i && (!act_q || (emit && fin));
  assign pop_o = pop;

  always_comb begin
    act_d = act_q;
    if (pop) begin
      act_d = 1'b1;
    end else if (emit && fin) begin
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_duty_q  <= '0;
      zero_duty_q <= '0;
      rst_slots_q <= rgbenc_pkg::ResetSlotsDefault;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbenc_pkg::REG_ONE_DUTY:    one_duty_q  <= cfg_wdata_i;
        rgbenc_pkg::REG_ZERO_DUTY:   zero_duty_q <= cfg_wdata_i;
        rgbenc_pkg::REG_RESET_SLOTS: rst_slots_q <= cfg_wdata_i[rgbenc_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      if (pop) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + rgbenc_pkg::IdxW'(1);
      end
      if (adv) begin
        ov_q <= act_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      word_q    <= pop_word_i.bits;
      fin_led_q <= pop_word_i.last_led;
    end else if (emit) begin
      word_q <= {word_q[rgbenc_pkg::BitsPerLed-2:0], 1'b0};
    end
    if (emit) begin
      if (idx_q == rgbenc_pkg::LatchIdx) begin
        duty_q <= '0;
        hold_q <= latch_hold;
        fend_q <= 1'b1;
        last_q <= 1'b1;
      end else begin
        duty_q <= word_q[rgbenc_pkg::BitsPerLed-1] ? one_duty_q : zero_duty_q;
        hold_q <= rgbenc_pkg::BitHold;
        fend_q <= 1'b0;
        last_q <= fin;
      end
    end
  end

  assign slot_o.valid      = ov_q;
  assign slot_o.duty       = duty_q;
  assign slot_o.hold_slots = hold_q;
  assign slot_o.frame_end  = fend_q;
  assign slot_o.last       = last_q;

endmodule

// ----- design/rgb_led_bit_slot_encoder_top.sv -----
// ----------------------------------------------------------------------------
// rgb_led_bit_slot_encoder_top
// Turns LED colours into timer compare slots, one per bit, plus latch reset.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  led_i     in   valid/ready          green, red, blue, last_led
//  slot_o    out  valid/ready          duty, hold_slots, frame_end, last
//  cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
//  One slot word leaves per cycle unless the output stalls: 24 per LED, 25
//  for the last LED of a frame, set by the serialiser's bit counter. A
//  two-word queue sits between input stage and serialiser, so the input keeps
//  taking words while the output stalls, until queue and input stage are full.
//  Reset clears control state; duty registers reset to 0, reset_slots to 48.
// ----------------------------------------------------------------------------
module rgb_led_bit_slot_encoder_top #(
  parameter int unsigned DUTY_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgbenc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DUTY_WIDTH-1:0]           cfg_wdata_i,
  rgbenc_led_if.sink                      led_i,
  rgbenc_slot_if.source                   slot_o
);

  logic                  push, push_ready, pop_valid, pop;
  rgbenc_pkg::led_word_t push_word, pop_word;

  rgbenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .led_i        (led_i),
    .push_o       (push),
    .push_word_o  (push_word),
    .push_ready_i (push_ready)
  );

  rgbenc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_word_o   (pop_word),
    .pop_i        (pop)
  );

  rgbenc_back #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_o       (pop),
    .slot_o      (slot_o)
  );

endmodule

// ----- design/rgbenc_checker.sv -----
// ----------------------------------------------------------------------------
// rgbenc_checker
// Port-level checks on the slot output of the encoder.
// ----------------------------------------------------------------------------
module rgbenc_checker #(
  parameter int unsigned DUTY_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [DUTY_WIDTH-1:0]         out_duty_i,
  input logic [rgbenc_pkg::HoldW-1:0]  out_hold_i,
  input logic                          out_fend_i,
  input logic                          out_last_i
);

  logic [rgbenc_pkg::IdxW-1:0] pos_q;
  logic                        acc;

  assign acc = out_valid_i && out_ready_i;

  // slot position within the current LED word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (acc) begin
      pos_q <= out_last_i ? '0 : pos_q + rgbenc_pkg::IdxW'(1);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_duty_i)
      && $stable(out_hold_i) && $stable(out_fend_i) && $stable(out_last_i))
    else $error("slot word changed while stalled");

  a_latch_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_fend_i |-> out_last_i && (out_duty_i == '0) && (out_hold_i != '0)
      && (pos_q == rgbenc_pkg::LatchIdx))
    else $error("bad latch reset slot");

  a_bit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !out_fend_i |-> (out_hold_i == rgbenc_pkg::BitHold)
      && (pos_q <= rgbenc_pkg::LastBitIdx))
    else $error("bad bit slot");

  a_word_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_last_i && !out_fend_i |-> (pos_q == rgbenc_pkg::LastBitIdx))
    else $error("LED word ended at wrong slot");

endmodule

bind rgb_led_bit_slot_encoder_top rgbenc_checker #(
  .DUTY_WIDTH (DUTY_WIDTH)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (slot_o.valid),
  .out_ready_i (slot_o.ready),
  .out_duty_i  (slot_o.duty),
  .out_hold_i  (slot_o.hold_slots),
  .out_fend_i  (slot_o.frame_end),
  .out_last_i  (slot_o.last)
);
